>>> hw/rtl/dlbb_pkg.sv
// Package for the display-list bounding box block.
// Holds coordinate types, command and register codes and the payload structs.
// Depends on nothing; every other file of the block uses it.
package dlbb_pkg;

	localparam int COORD_BITS     = 32;
	localparam int FRAC_BITS      = 16;
	localparam int NUM_AXES       = 3;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CODE_BITS      = 8;
	localparam int COUNT_BITS     = 32;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [CODE_BITS-1:0]         code_t;
	typedef logic [COUNT_BITS-1:0]        count_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam coord_t UNIT      = coord_t'({{(COORD_BITS-1){1'b0}}, 1'b1} << FRAC_BITS);

	typedef enum logic [CODE_BITS-1:0] {
		CMD_LINE_MOVE      = 8'd0,
		CMD_LINE_DRAW      = 8'd1,
		CMD_POLY_START     = 8'd2,
		CMD_POLY_MOVE      = 8'd3,
		CMD_POLY_DRAW      = 8'd4,
		CMD_POLY_END       = 8'd5,
		CMD_POLY_VNORMAL   = 8'd6,
		CMD_TRI_START      = 8'd7,
		CMD_TRI_MOVE       = 8'd8,
		CMD_TRI_DRAW       = 8'd9,
		CMD_TRI_END        = 8'd10,
		CMD_TRI_VNORMAL    = 8'd11,
		CMD_POINT_DRAW     = 8'd12,
		CMD_MODEL_MATRIX   = 8'd13,
		CMD_DISPLAY_MATRIX = 8'd14,
		CMD_POINT_SIZE     = 8'd15,
		CMD_LINE_WIDTH     = 8'd16
	} cmd_code_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SEED_MIN_X = 3'd0,
		CFG_SEED_MIN_Y = 3'd1,
		CFG_SEED_MIN_Z = 3'd2,
		CFG_SEED_MAX_X = 3'd3,
		CFG_SEED_MAX_Y = 3'd4,
		CFG_SEED_MAX_Z = 3'd5
	} cfg_index_t;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_BAD  = 1'b1;

	typedef struct packed {
		code_t  cmd_code;
		coord_t coord_x;
		coord_t coord_y;
		coord_t coord_z;
		logic   first_item;
		logic   last_item;
	} cmd_item_t;

	typedef struct packed {
		coord_t lower_x;
		coord_t lower_y;
		coord_t lower_z;
		coord_t upper_x;
		coord_t upper_y;
		coord_t upper_z;
		count_t item_total;
		logic   display_flag;
		logic   status;
		code_t  bad_command;
	} bbox_result_t;

	// Box accumulator state; axis 0 is x, 1 is y, 2 is z.
	typedef struct packed {
		coord_t [NUM_AXES-1:0] lower;
		coord_t [NUM_AXES-1:0] upper;
		logic                  skip_mode;
		logic                  display_seen;
		count_t                count;
		logic                  halted;
	} box_state_t;

endpackage

>>> hw/rtl/dlbb_update.sv
// Next-state and result logic of the display-list bounding box block.
// Decodes one command, widens the box with saturating offsets and forms the result.
// Depends on dlbb_pkg.
module dlbb_update (
	input  dlbb_pkg::cmd_item_t                     item,
	input  dlbb_pkg::box_state_t                    state,
	input  dlbb_pkg::coord_t [dlbb_pkg::NUM_AXES-1:0] seed_lo,
	input  dlbb_pkg::coord_t [dlbb_pkg::NUM_AXES-1:0] seed_hi,
	output dlbb_pkg::box_state_t                    next_state,
	output logic                                    emit,
	output dlbb_pkg::bbox_result_t                  result
);

	// Adds or subtracts one unit (or nothing) and clamps to the coordinate range.
	function automatic dlbb_pkg::coord_t sat_offset(input dlbb_pkg::coord_t p,
			input logic neg, input logic use_unit);
		logic signed [dlbb_pkg::COORD_BITS:0] ext;
		logic signed [dlbb_pkg::COORD_BITS:0] off;
		logic signed [dlbb_pkg::COORD_BITS:0] sum;
		dlbb_pkg::coord_t                     res;
		ext = {p[dlbb_pkg::COORD_BITS-1], p};
		off = use_unit ? {1'b0, dlbb_pkg::UNIT} : '0;
		sum = neg ? ext - off : ext + off;
		if (sum[dlbb_pkg::COORD_BITS] != sum[dlbb_pkg::COORD_BITS-1]) begin
			res = sum[dlbb_pkg::COORD_BITS] ? dlbb_pkg::COORD_MIN : dlbb_pkg::COORD_MAX;
		end else begin
			res = sum[dlbb_pkg::COORD_BITS-1:0];
		end
		return res;
	endfunction

	function automatic dlbb_pkg::bbox_result_t make_result(input dlbb_pkg::box_state_t s,
			input logic st, input dlbb_pkg::code_t code);
		dlbb_pkg::bbox_result_t r;
		r.lower_x      = s.lower[0];
		r.lower_y      = s.lower[1];
		r.lower_z      = s.lower[2];
		r.upper_x      = s.upper[0];
		r.upper_y      = s.upper[1];
		r.upper_z      = s.upper[2];
		r.item_total   = s.count;
		r.display_flag = s.display_seen;
		r.status       = st;
		r.bad_command  = code;
		return r;
	endfunction

	dlbb_pkg::box_state_t                     eff;
	dlbb_pkg::coord_t [dlbb_pkg::NUM_AXES-1:0] pnt;
	dlbb_pkg::coord_t                         lo_c;
	dlbb_pkg::coord_t                         hi_c;
	logic                                     do_widen;
	logic                                     use_unit;
	logic                                     bad;

	assign pnt = {item.coord_z, item.coord_y, item.coord_x};

	always_comb begin
		eff = state;
		if (item.first_item) begin
			eff.lower        = seed_lo;
			eff.upper        = seed_hi;
			eff.skip_mode    = 1'b0;
			eff.display_seen = 1'b0;
			eff.count        = '0;
			eff.halted       = 1'b0;
		end

		next_state = eff;
		emit       = 1'b0;
		result     = make_result(eff, dlbb_pkg::STATUS_DONE, '0);
		do_widen   = 1'b0;
		use_unit   = 1'b0;
		bad        = 1'b0;
		lo_c       = '0;
		hi_c       = '0;

		if (!eff.halted) begin
			// While skipping, only a model matrix is decoded; everything else just counts.
			if (!(eff.skip_mode && item.cmd_code != dlbb_pkg::CMD_MODEL_MATRIX)) begin
				next_state.skip_mode = 1'b0;
				case (item.cmd_code)
					dlbb_pkg::CMD_LINE_MOVE, dlbb_pkg::CMD_LINE_DRAW,
					dlbb_pkg::CMD_POLY_MOVE, dlbb_pkg::CMD_POLY_DRAW,
					dlbb_pkg::CMD_POLY_END, dlbb_pkg::CMD_TRI_MOVE,
					dlbb_pkg::CMD_TRI_DRAW, dlbb_pkg::CMD_TRI_END: begin
						do_widen = 1'b1;
					end
					dlbb_pkg::CMD_DISPLAY_MATRIX: begin
						next_state.skip_mode    = 1'b1;
						next_state.display_seen = 1'b1;
						do_widen = 1'b1;
						use_unit = 1'b1;
					end
					dlbb_pkg::CMD_POINT_DRAW: begin
						do_widen = 1'b1;
						use_unit = 1'b1;
					end
					dlbb_pkg::CMD_POLY_START, dlbb_pkg::CMD_POLY_VNORMAL,
					dlbb_pkg::CMD_TRI_START, dlbb_pkg::CMD_TRI_VNORMAL,
					dlbb_pkg::CMD_MODEL_MATRIX, dlbb_pkg::CMD_POINT_SIZE,
					dlbb_pkg::CMD_LINE_WIDTH: begin
					end
					default: begin
						bad = 1'b1;
					end
				endcase
			end

			if (bad) begin
				// The unknown command leaves box and count as they were.
				next_state        = eff;
				next_state.halted = 1'b1;
				emit              = 1'b1;
				result            = make_result(eff, dlbb_pkg::STATUS_BAD, item.cmd_code);
			end else begin
				if (do_widen) begin
					for (int i = 0; i < dlbb_pkg::NUM_AXES; i++) begin
						lo_c = sat_offset(pnt[i], 1'b1, use_unit);
						hi_c = sat_offset(pnt[i], 1'b0, use_unit);
						if ($signed(lo_c) < $signed(eff.lower[i])) begin
							next_state.lower[i] = lo_c;
						end
						if ($signed(hi_c) > $signed(eff.upper[i])) begin
							next_state.upper[i] = hi_c;
						end
					end
				end
				if (eff.count != '1) begin
					next_state.count = eff.count + dlbb_pkg::count_t'(1);
				end
				if (item.last_item) begin
					emit   = 1'b1;
					result = make_result(next_state, dlbb_pkg::STATUS_DONE, '0);
				end
			end
		end
	end

endmodule

>>> hw/rtl/dlbb_out_buf.sv
// Two-entry result queue of the display-list bounding box block.
// Lets the block keep taking commands while one result waits for the receiver.
// Depends on dlbb_pkg.
module dlbb_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  dlbb_pkg::bbox_result_t push_data,
	output logic                   space,
	output logic                   out_valid,
	input  logic                   out_ready,
	output dlbb_pkg::bbox_result_t out_item
);

	dlbb_pkg::bbox_result_t slot0_q;
	dlbb_pkg::bbox_result_t slot1_q;
	logic [1:0]             count_q;
	logic                   pop;

	assign out_valid = (count_q != 2'd0);
	assign out_item  = slot0_q;
	assign space     = (count_q != 2'd2);
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !push) begin
			slot0_q <= slot1_q;
		end else if (push && !pop) begin
			if (count_q == 2'd0) begin
				slot0_q <= push_data;
			end else begin
				slot1_q <= push_data;
			end
		end else if (push && pop) begin
			// One entry leaves as the new one arrives, so the new one becomes the head.
			slot0_q <= push_data;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue count out of range");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 2'd1)
		else $error("result queue lost a pushed transaction");

	a_shift_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push && count_q == 2'd2 |=> out_item == $past(slot1_q))
		else $error("second result did not move to the head");

endmodule

>>> hw/rtl/display_list_bounding_box.sv
// Top level of the display-list bounding box block.
// Holds seed registers and box state, and ties together dlbb_update and dlbb_out_buf.
// Depends on dlbb_pkg, dlbb_update and dlbb_out_buf.
//
// Commands arrive on the in_valid/in_ready channel as a dlbb_pkg::cmd_item_t.
// Each transaction is decoded and folded into the box in the cycle it is
// accepted; the state registers feed back so a command can be taken every
// cycle while in_ready is high. A command that ends a list or carries an
// unknown code pushes one result into a two-entry queue; into an empty queue
// it is visible on out_valid/out_item in the cycle after the command was
// accepted. While the receiver holds out_ready low, commands are still taken
// until two results wait, and only then does in_ready fall.
// Seed corners are written through cfg_valid/cfg_ready/cfg_index/cfg_data,
// one register per transaction; cfg_ready is always high and writes beyond
// the last register are dropped. Seeds take effect at the next first item.
// Reset sets the seeds and corners to an empty box (lower at the most
// positive value, upper at the most negative), clears flags and the count,
// and empties the result queue.
module display_list_bounding_box (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  dlbb_pkg::cmd_item_t                  in_item,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output dlbb_pkg::bbox_result_t               out_item,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dlbb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  dlbb_pkg::coord_t                     cfg_data
);

	dlbb_pkg::coord_t [dlbb_pkg::NUM_AXES-1:0] seed_lo_q;
	dlbb_pkg::coord_t [dlbb_pkg::NUM_AXES-1:0] seed_hi_q;
	dlbb_pkg::box_state_t                      state_q;
	dlbb_pkg::box_state_t                      next_state;
	dlbb_pkg::bbox_result_t                    result;
	logic                                      emit;
	logic                                      space;
	logic                                      accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = space;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_lo_q <= {dlbb_pkg::NUM_AXES{dlbb_pkg::COORD_MAX}};
			seed_hi_q <= {dlbb_pkg::NUM_AXES{dlbb_pkg::COORD_MIN}};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dlbb_pkg::CFG_SEED_MIN_X: seed_lo_q[0] <= cfg_data;
				dlbb_pkg::CFG_SEED_MIN_Y: seed_lo_q[1] <= cfg_data;
				dlbb_pkg::CFG_SEED_MIN_Z: seed_lo_q[2] <= cfg_data;
				dlbb_pkg::CFG_SEED_MAX_X: seed_hi_q[0] <= cfg_data;
				dlbb_pkg::CFG_SEED_MAX_Y: seed_hi_q[1] <= cfg_data;
				dlbb_pkg::CFG_SEED_MAX_Z: seed_hi_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.lower        <= {dlbb_pkg::NUM_AXES{dlbb_pkg::COORD_MAX}};
			state_q.upper        <= {dlbb_pkg::NUM_AXES{dlbb_pkg::COORD_MIN}};
			state_q.skip_mode    <= 1'b0;
			state_q.display_seen <= 1'b0;
			state_q.count        <= '0;
			state_q.halted       <= 1'b0;
		end else if (accept) begin
			state_q <= next_state;
		end
	end

	dlbb_update u_update (
		.item       (in_item),
		.state      (state_q),
		.seed_lo    (seed_lo_q),
		.seed_hi    (seed_hi_q),
		.next_state (next_state),
		.emit       (emit),
		.result     (result)
	);

	dlbb_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && emit),
		.push_data (result),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && state_q.halted && !in_item.first_item |=> $stable(state_q))
		else $error("halted list changed state");

	a_halt_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && state_q.halted && !in_item.first_item |-> !emit)
		else $error("halted list produced a result");

	a_bad_sets_halt: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit && result.status == dlbb_pkg::STATUS_BAD |=> state_q.halted)
		else $error("error transaction did not halt the list");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for display_list_bounding_box: it drives display-list
// commands and seed writes, and predicts every box result with its own model.
// Depends on dlbb_pkg and display_list_bounding_box from the RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int                PHASES          = 8;
	localparam int                ITEMS_PER_PHASE = 250;
	localparam int                HOLD_CYCLES     = 300;
	localparam int                BURST_ITEMS     = 40;
	localparam int unsigned       CYCLE_LIMIT     = 400000;
	localparam dlbb_pkg::code_t   CODE_LAST       = '1;
	// Index past the last seed register; the block drops writes to it.
	localparam logic [dlbb_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED = 3'd7;

	// Tracks the box per list and queues the result each command should produce.
	class bbox_tracker;
		dlbb_pkg::coord_t       seed_lo [dlbb_pkg::NUM_AXES];
		dlbb_pkg::coord_t       seed_hi [dlbb_pkg::NUM_AXES];
		dlbb_pkg::coord_t       lower [dlbb_pkg::NUM_AXES];
		dlbb_pkg::coord_t       upper [dlbb_pkg::NUM_AXES];
		bit                     skipping;
		bit                     display_seen;
		bit                     halted;
		dlbb_pkg::count_t       count;
		dlbb_pkg::bbox_result_t pending_boxes [$];
		int                     mismatches;

		function new();
			for (int a = 0; a < dlbb_pkg::NUM_AXES; a++) begin
				seed_lo[a] = dlbb_pkg::COORD_MAX;
				seed_hi[a] = dlbb_pkg::COORD_MIN;
				lower[a]   = dlbb_pkg::COORD_MAX;
				upper[a]   = dlbb_pkg::COORD_MIN;
			end
			skipping     = 1'b0;
			display_seen = 1'b0;
			halted       = 1'b0;
			count        = '0;
			mismatches   = 0;
		endfunction

		function void write_seed(logic [dlbb_pkg::CFG_INDEX_BITS-1:0] idx,
				dlbb_pkg::coord_t value);
			case (idx)
				dlbb_pkg::CFG_SEED_MIN_X: seed_lo[0] = value;
				dlbb_pkg::CFG_SEED_MIN_Y: seed_lo[1] = value;
				dlbb_pkg::CFG_SEED_MIN_Z: seed_lo[2] = value;
				dlbb_pkg::CFG_SEED_MAX_X: seed_hi[0] = value;
				dlbb_pkg::CFG_SEED_MAX_Y: seed_hi[1] = value;
				dlbb_pkg::CFG_SEED_MAX_Z: seed_hi[2] = value;
				default: ;
			endcase
		endfunction

		function dlbb_pkg::coord_t shifted(dlbb_pkg::coord_t p, longint delta);
			longint sum;
			sum = longint'(p) + delta;
			if (sum > longint'(dlbb_pkg::COORD_MAX))
				return dlbb_pkg::COORD_MAX;
			if (sum < longint'(dlbb_pkg::COORD_MIN))
				return dlbb_pkg::COORD_MIN;
			return dlbb_pkg::coord_t'(sum);
		endfunction

		function void grow(dlbb_pkg::cmd_item_t it, longint off);
			dlbb_pkg::coord_t pt [dlbb_pkg::NUM_AXES];
			dlbb_pkg::coord_t lo;
			dlbb_pkg::coord_t hi;
			pt[0] = it.coord_x;
			pt[1] = it.coord_y;
			pt[2] = it.coord_z;
			for (int a = 0; a < dlbb_pkg::NUM_AXES; a++) begin
				lo = shifted(pt[a], -off);
				hi = shifted(pt[a], off);
				if (lo < lower[a])
					lower[a] = lo;
				if (hi > upper[a])
					upper[a] = hi;
			end
		endfunction

		function void post(logic st, dlbb_pkg::code_t code);
			dlbb_pkg::bbox_result_t r;
			r.lower_x      = lower[0];
			r.lower_y      = lower[1];
			r.lower_z      = lower[2];
			r.upper_x      = upper[0];
			r.upper_y      = upper[1];
			r.upper_z      = upper[2];
			r.item_total   = count;
			r.display_flag = display_seen;
			r.status       = st;
			r.bad_command  = code;
			pending_boxes.push_back(r);
		endfunction

		function void accept_command(dlbb_pkg::cmd_item_t it);
			if (it.first_item) begin
				for (int a = 0; a < dlbb_pkg::NUM_AXES; a++) begin
					lower[a] = seed_lo[a];
					upper[a] = seed_hi[a];
				end
				skipping     = 1'b0;
				display_seen = 1'b0;
				count        = '0;
				halted       = 1'b0;
			end
			if (halted)
				return;
			// While skipping, everything but a model matrix is counted and otherwise ignored.
			if (!skipping || it.cmd_code == dlbb_pkg::CMD_MODEL_MATRIX) begin
				skipping = 1'b0;
				case (it.cmd_code)
					dlbb_pkg::CMD_LINE_MOVE, dlbb_pkg::CMD_LINE_DRAW,
					dlbb_pkg::CMD_POLY_MOVE, dlbb_pkg::CMD_POLY_DRAW,
					dlbb_pkg::CMD_POLY_END, dlbb_pkg::CMD_TRI_MOVE,
					dlbb_pkg::CMD_TRI_DRAW, dlbb_pkg::CMD_TRI_END: grow(it, 0);
					dlbb_pkg::CMD_DISPLAY_MATRIX: begin
						skipping     = 1'b1;
						display_seen = 1'b1;
						grow(it, dlbb_pkg::UNIT);
					end
					dlbb_pkg::CMD_POINT_DRAW: grow(it, dlbb_pkg::UNIT);
					dlbb_pkg::CMD_POLY_START, dlbb_pkg::CMD_POLY_VNORMAL,
					dlbb_pkg::CMD_TRI_START, dlbb_pkg::CMD_TRI_VNORMAL,
					dlbb_pkg::CMD_MODEL_MATRIX, dlbb_pkg::CMD_POINT_SIZE,
					dlbb_pkg::CMD_LINE_WIDTH: ;
					default: begin
						halted = 1'b1;
						post(dlbb_pkg::STATUS_BAD, it.cmd_code);
						return;
					end
				endcase
			end
			if (count != '1)
				count++;
			if (it.last_item)
				post(dlbb_pkg::STATUS_DONE, '0);
		endfunction

		function void compare(string field, logic [31:0] exp, logic [31:0] got);
			if (exp !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch in %s: expected %h, got %h", field, exp, got);
			end
		endfunction

		function void check_box(dlbb_pkg::bbox_result_t got);
			dlbb_pkg::bbox_result_t exp;
			if (pending_boxes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with none expected: %h", got);
				return;
			end
			exp = pending_boxes.pop_front();
			compare("lower_x", exp.lower_x, got.lower_x);
			compare("lower_y", exp.lower_y, got.lower_y);
			compare("lower_z", exp.lower_z, got.lower_z);
			compare("upper_x", exp.upper_x, got.upper_x);
			compare("upper_y", exp.upper_y, got.upper_y);
			compare("upper_z", exp.upper_z, got.upper_z);
			compare("item_total", exp.item_total, got.item_total);
			compare("display_flag", exp.display_flag, got.display_flag);
			compare("status", exp.status, got.status);
			compare("bad_command", exp.bad_command, got.bad_command);
		endfunction
	endclass

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                in_valid  = 1'b0;
	logic                                in_ready;
	dlbb_pkg::cmd_item_t                 in_item   = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	dlbb_pkg::bbox_result_t              out_item;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [dlbb_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	dlbb_pkg::coord_t                    cfg_data  = '0;

	bbox_tracker boxes     = new();
	bit          quiet     = 1'b0;
	bit          long_hold = 1'b0;
	int unsigned cycles    = 0;

	display_list_bounding_box u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Mostly ordinary values, with a share near both ends of the range and near zero.
	function automatic dlbb_pkg::coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return dlbb_pkg::COORD_MAX
				- dlbb_pkg::coord_t'($urandom_range(0, 2 * dlbb_pkg::UNIT));
			1: return dlbb_pkg::COORD_MIN
				+ dlbb_pkg::coord_t'($urandom_range(0, 2 * dlbb_pkg::UNIT));
			2, 3, 4: return dlbb_pkg::coord_t'($urandom_range(0, 2 * dlbb_pkg::UNIT))
				- dlbb_pkg::UNIT;
			default: return dlbb_pkg::coord_t'($urandom);
		endcase
	endfunction

	function automatic dlbb_pkg::code_t pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return dlbb_pkg::code_t'($urandom_range(dlbb_pkg::CMD_LINE_WIDTH,
				dlbb_pkg::CMD_LINE_MOVE));
		if (r < 85)
			return dlbb_pkg::CMD_MODEL_MATRIX;
		if (r < 92)
			return dlbb_pkg::CMD_DISPLAY_MATRIX;
		if (r < 97)
			return dlbb_pkg::CMD_POINT_DRAW;
		return dlbb_pkg::code_t'($urandom_range(CODE_LAST, dlbb_pkg::CMD_LINE_WIDTH + 1));
	endfunction

	function automatic dlbb_pkg::cmd_item_t mk(dlbb_pkg::code_t code, dlbb_pkg::coord_t x,
			dlbb_pkg::coord_t y, dlbb_pkg::coord_t z, logic first, logic last);
		dlbb_pkg::cmd_item_t it;
		it.cmd_code   = code;
		it.coord_x    = x;
		it.coord_y    = y;
		it.coord_z    = z;
		it.first_item = first;
		it.last_item  = last;
		return it;
	endfunction

	task automatic send_item(dlbb_pkg::cmd_item_t it);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		boxes.accept_command(it);
	endtask

	task automatic write_seed(logic [dlbb_pkg::CFG_INDEX_BITS-1:0] idx,
			dlbb_pkg::coord_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		boxes.write_seed(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every expected box has come back and the block has gone quiet.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (boxes.pending_boxes.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Well-formed lists with random content, plus a share of lists made of noise.
	task automatic run_lists(int n);
		int                  sent;
		int                  len;
		bit                  noise;
		dlbb_pkg::cmd_item_t it;
		sent = 0;
		while (sent < n) begin
			len   = $urandom_range(1, 12);
			noise = ($urandom_range(0, 99) < 8);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 99) < 3)
					quiet = !quiet;
				it.coord_x = rand_coord();
				it.coord_y = rand_coord();
				it.coord_z = rand_coord();
				if (noise) begin
					it.cmd_code   = dlbb_pkg::code_t'($urandom);
					it.first_item = $urandom_range(0, 1);
					it.last_item  = $urandom_range(0, 1);
				end else begin
					it.cmd_code   = pick_code();
					it.first_item = (k == 0) && ($urandom_range(0, 9) != 0);
					it.last_item  = (k == len - 1);
				end
				send_item(it);
				sent++;
			end
		end
	endtask

	// The receiver holds off for a long stretch while one-item lists arrive
	// back to back, so the result queue fills and the input stalls.
	task automatic squeeze();
		bit was_quiet;
		was_quiet = quiet;
		quiet     = 1'b1;
		long_hold = 1'b1;
		for (int k = 0; k < BURST_ITEMS; k++)
			send_item(mk(dlbb_pkg::CMD_LINE_DRAW, rand_coord(), rand_coord(), rand_coord(),
				1'b1, 1'b1));
		quiet = was_quiet;
	endtask

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 13);
			if (long_hold) begin
				gap       = HOLD_CYCLES;
				long_hold = 1'b0;
			end
			@(negedge clk);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			boxes.check_box(out_item);
		end
	end

	initial begin
		dlbb_pkg::coord_t v;
		bit               is_lo;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed lists on the reset seeds.
		send_item(mk(dlbb_pkg::CMD_LINE_MOVE, '0, '0, '0, 1'b1, 1'b0));
		send_item(mk(dlbb_pkg::CMD_LINE_DRAW, dlbb_pkg::COORD_MAX, dlbb_pkg::COORD_MIN,
			dlbb_pkg::UNIT, 1'b0, 1'b0));
		send_item(mk(dlbb_pkg::CMD_POINT_DRAW, dlbb_pkg::COORD_MAX, dlbb_pkg::COORD_MIN, '0,
			1'b0, 1'b0));
		send_item(mk(dlbb_pkg::CMD_POINT_DRAW, dlbb_pkg::COORD_MIN, dlbb_pkg::COORD_MAX,
			-dlbb_pkg::UNIT, 1'b0, 1'b0));
		for (int c = dlbb_pkg::CMD_POLY_START; c <= dlbb_pkg::CMD_LINE_WIDTH; c++)
			if (c != dlbb_pkg::CMD_POINT_DRAW && c != dlbb_pkg::CMD_DISPLAY_MATRIX)
				send_item(mk(dlbb_pkg::code_t'(c), rand_coord(), rand_coord(), rand_coord(),
					1'b0, c == dlbb_pkg::CMD_LINE_WIDTH));
		// A command after a last item keeps growing the same box.
		send_item(mk(dlbb_pkg::CMD_LINE_DRAW, 1, 2, 3, 1'b0, 1'b1));
		// Skip mode swallows draws and unknown codes until a model matrix.
		send_item(mk(dlbb_pkg::CMD_DISPLAY_MATRIX, dlbb_pkg::COORD_MIN + 1,
			dlbb_pkg::COORD_MAX - 1, '0, 1'b1, 1'b0));
		send_item(mk(dlbb_pkg::CMD_LINE_DRAW, dlbb_pkg::COORD_MAX, dlbb_pkg::COORD_MAX,
			dlbb_pkg::COORD_MAX, 1'b0, 1'b0));
		send_item(mk(CODE_LAST, '0, '0, '0, 1'b0, 1'b0));
		send_item(mk(dlbb_pkg::CMD_MODEL_MATRIX, '0, '0, '0, 1'b0, 1'b0));
		send_item(mk(dlbb_pkg::code_t'(dlbb_pkg::CMD_LINE_WIDTH + 1), '1, '1, '1,
			1'b0, 1'b0));
		// The list is halted now, so this last item gives nothing.
		send_item(mk(dlbb_pkg::CMD_LINE_DRAW, '0, '0, '0, 1'b0, 1'b1));
		send_item(mk(dlbb_pkg::code_t'(8'hAA), '0, '0, '0, 1'b1, 1'b1));
		send_item(mk(dlbb_pkg::CMD_POINT_DRAW, -dlbb_pkg::UNIT, dlbb_pkg::UNIT, '0,
			1'b1, 1'b1));
		settle();

		for (int ph = 1; ph <= PHASES; ph++) begin
			for (int a = dlbb_pkg::CFG_SEED_MIN_X; a <= dlbb_pkg::CFG_SEED_MAX_Z; a++) begin
				is_lo = (a < dlbb_pkg::CFG_SEED_MAX_X);
				case (ph)
					1: v = '0;
					2: v = is_lo ? dlbb_pkg::COORD_MIN : dlbb_pkg::COORD_MAX;
					3: v = is_lo ? dlbb_pkg::COORD_MAX : dlbb_pkg::COORD_MIN;
					default: v = rand_coord();
				endcase
				write_seed(dlbb_pkg::CFG_INDEX_BITS'(a), v);
			end
			if (ph == 1)
				write_seed(CFG_UNUSED, dlbb_pkg::COORD_MIN);
			run_lists(ITEMS_PER_PHASE);
			if (ph == 3 || ph == 6)
				squeeze();
			settle();
		end

		if (boxes.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
